FILE: rtl/core/lfpc_pkg.sv
// ----------------------------------------------------------------------------
// lfpc_pkg
// Shared types, codes and defaults for the link failover path controller.
// ----------------------------------------------------------------------------
package lfpc_pkg;

  // Default width of the saturating event counters
  localparam int unsigned CounterBitsDef = 8;

  // Configuration register width and index width
  localparam int unsigned CfgW    = 8;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_FAILS_TO_DEGRADED         = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FAILS_TO_UNAVAILABLE      = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PROBES_TO_HEALTHY         = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_RELAY_FAILS_TO_REDISCOVER = 2'd3;

  // Configuration reset values
  localparam logic [CfgW-1:0] FailsToDegradedRst        = 8'd3;
  localparam logic [CfgW-1:0] FailsToUnavailableRst     = 8'd5;
  localparam logic [CfgW-1:0] ProbesToHealthyRst        = 8'd2;
  localparam logic [CfgW-1:0] RelayFailsToRediscoverRst = 8'd3;

  typedef enum logic [2:0] {
    CMD_DIRECT_RESULT = 3'd0,
    CMD_PROBE         = 3'd1,
    CMD_CANDIDATE     = 3'd2,
    CMD_RELAY_AUTH    = 3'd3,
    CMD_RELAY_RESULT  = 3'd4,
    CMD_PEER_LOST     = 3'd5,
    CMD_REDISCOVER    = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ST_NONE   = 2'd0,
    ST_POLICY = 2'd1,
    ST_REJECT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    H_HEALTHY     = 2'd0,
    H_DEGRADED    = 2'd1,
    H_UNAVAILABLE = 2'd2,
    H_RECOVERING  = 2'd3
  } health_e;

  typedef enum logic [2:0] {
    P_DIRECT       = 3'd0,
    P_DEGRADED     = 3'd1,
    P_DISCOVERY    = 3'd2,
    P_RELAY_AUTH   = 3'd3,
    P_RELAY_ACTIVE = 3'd4,
    P_REDISCOVERY  = 3'd5,
    P_RECOVERY     = 3'd6
  } path_e;

  // Configuration register set
  typedef struct packed {
    logic [CfgW-1:0] fails_to_degraded;
    logic [CfgW-1:0] fails_to_unavailable;
    logic [CfgW-1:0] probes_to_healthy;
    logic [CfgW-1:0] relay_fails_to_rediscover;
  } cfg_t;

  // Health machine verdict handed to the path machine
  typedef struct packed {
    status_e status;  // policy or reject verdict of commands 0 and 1
    health_e health;  // health after the request
    logic    follow;  // health request took effect, path machine must follow
  } health_res_t;

endpackage

FILE: rtl/core/lfpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// lfpc_cfg_regs
// Write-only configuration register file with reset defaults.
// ----------------------------------------------------------------------------
module lfpc_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lfpc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [lfpc_pkg::CfgW-1:0]    cfg_wdata_i,
  output lfpc_pkg::cfg_t               cfg_o
);
  import lfpc_pkg::*;

  cfg_t cfg_d, cfg_q;

  // Decode the write index
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FAILS_TO_DEGRADED:         cfg_d.fails_to_degraded         = cfg_wdata_i;
        CFG_FAILS_TO_UNAVAILABLE:      cfg_d.fails_to_unavailable      = cfg_wdata_i;
        CFG_PROBES_TO_HEALTHY:         cfg_d.probes_to_healthy         = cfg_wdata_i;
        CFG_RELAY_FAILS_TO_REDISCOVER: cfg_d.relay_fails_to_rediscover = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fails_to_degraded         <= FailsToDegradedRst;
      cfg_q.fails_to_unavailable      <= FailsToUnavailableRst;
      cfg_q.probes_to_healthy         <= ProbesToHealthyRst;
      cfg_q.relay_fails_to_rediscover <= RelayFailsToRediscoverRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/lfpc_health.sv
// ----------------------------------------------------------------------------
// lfpc_health
// Direct-link health machine with saturating failure and probe counters.
// ----------------------------------------------------------------------------
module lfpc_health #(
  parameter int unsigned CounterBits = lfpc_pkg::CounterBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  lfpc_pkg::cmd_e        cmd_i,
  input  logic                  ok_i,
  input  lfpc_pkg::cfg_t        cfg_i,
  output lfpc_pkg::health_res_t res_o
);
  import lfpc_pkg::*;

  localparam int unsigned CmpW = (CounterBits > CfgW) ? CounterBits : CfgW;
  localparam logic [CounterBits-1:0] CntMax = {CounterBits{1'b1}};

  health_e                health_d, health_q;
  logic [CounterBits-1:0] dfail_d, dfail_q;
  logic [CounterBits-1:0] probe_d, probe_q;
  logic [CounterBits-1:0] dfail_inc, probe_inc;
  logic                   policy_ok;
  logic                   follow;
  status_e                status;

  // Saturating increments
  assign dfail_inc = (dfail_q == CntMax) ? CntMax : dfail_q + 1'b1;
  assign probe_inc = (probe_q == CntMax) ? CntMax : probe_q + 1'b1;

  assign policy_ok = (cfg_i.fails_to_degraded != '0) &&
                     (cfg_i.fails_to_unavailable >= cfg_i.fails_to_degraded) &&
                     (cfg_i.probes_to_healthy != '0);

  // Evaluate the request against the health state
  always_comb begin
    health_d = health_q;
    dfail_d  = dfail_q;
    probe_d  = probe_q;
    follow   = 1'b0;
    status   = ST_NONE;
    case (cmd_i)
      CMD_DIRECT_RESULT: begin
        if (!policy_ok) begin
          status = ST_POLICY;
        end else if (health_q == H_UNAVAILABLE || health_q == H_RECOVERING) begin
          status = ST_REJECT;
        end else begin
          follow  = 1'b1;
          probe_d = '0;
          if (ok_i) begin
            dfail_d  = '0;
            health_d = H_HEALTHY;
          end else begin
            dfail_d = dfail_inc;
            if (CmpW'(dfail_inc) >= CmpW'(cfg_i.fails_to_unavailable)) begin
              health_d = H_UNAVAILABLE;
            end else if (CmpW'(dfail_inc) >= CmpW'(cfg_i.fails_to_degraded)) begin
              health_d = H_DEGRADED;
            end
          end
        end
      end
      CMD_PROBE: begin
        if (!policy_ok) begin
          status = ST_POLICY;
        end else if (health_q != H_UNAVAILABLE && health_q != H_RECOVERING) begin
          status = ST_REJECT;
        end else begin
          follow = 1'b1;
          if (!ok_i) begin
            probe_d  = '0;
            health_d = H_UNAVAILABLE;
          end else if (CmpW'(probe_inc) >= CmpW'(cfg_i.probes_to_healthy)) begin
            dfail_d  = '0;
            probe_d  = '0;
            health_d = H_HEALTHY;
          end else begin
            probe_d  = probe_inc;
            health_d = H_RECOVERING;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      health_q <= H_HEALTHY;
      dfail_q  <= '0;
      probe_q  <= '0;
    end else if (en_i && follow) begin
      health_q <= health_d;
      dfail_q  <= dfail_d;
      probe_q  <= probe_d;
    end
  end

  assign res_o.status = status;
  assign res_o.health = health_d;
  assign res_o.follow = follow;

endmodule

FILE: rtl/core/lfpc_path.sv
// ----------------------------------------------------------------------------
// lfpc_path
// Seven-mode path machine with relay failure counter and saved relay mode.
// ----------------------------------------------------------------------------
module lfpc_path #(
  parameter int unsigned CounterBits = lfpc_pkg::CounterBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  lfpc_pkg::cmd_e         cmd_i,
  input  logic                   ok_i,
  input  lfpc_pkg::health_res_t  hres_i,
  input  logic [lfpc_pkg::CfgW-1:0] relay_thr_i,
  output lfpc_pkg::status_e      status_o,
  output lfpc_pkg::path_e        path_o,
  output logic [CounterBits-1:0] rfail_o
);
  import lfpc_pkg::*;

  localparam int unsigned CmpW = (CounterBits > CfgW) ? CounterBits : CfgW;
  localparam logic [CounterBits-1:0] CntMax = {CounterBits{1'b1}};

  path_e                  path_d, path_q;
  path_e                  saved_d, saved_q;
  logic [CounterBits-1:0] rfail_d, rfail_q;
  logic [CounterBits-1:0] rfail_inc;
  logic                   cur_relay_side;
  logic                   saved_relay_side;
  status_e                status;

  assign rfail_inc = (rfail_q == CntMax) ? CntMax : rfail_q + 1'b1;

  assign cur_relay_side = (path_q == P_DISCOVERY) || (path_q == P_RELAY_AUTH) ||
                          (path_q == P_RELAY_ACTIVE) || (path_q == P_REDISCOVERY);
  assign saved_relay_side = (saved_q == P_DISCOVERY) || (saved_q == P_RELAY_AUTH) ||
                            (saved_q == P_RELAY_ACTIVE) || (saved_q == P_REDISCOVERY);

  // Evaluate the request against the path state
  always_comb begin
    path_d  = path_q;
    saved_d = saved_q;
    rfail_d = rfail_q;
    status  = ST_NONE;
    case (cmd_i) inside
      CMD_DIRECT_RESULT, CMD_PROBE: begin
        if (hres_i.status != ST_NONE) begin
          status = hres_i.status;
        end else if (relay_thr_i == '0) begin
          status = ST_POLICY;
        end else if (hres_i.follow) begin
          // Follow the new health mode
          case (hres_i.health)
            H_HEALTHY: begin
              path_d  = P_DIRECT;
              rfail_d = '0;
            end
            H_DEGRADED: begin
              if (path_q == P_DIRECT) path_d = P_DEGRADED;
            end
            H_UNAVAILABLE: begin
              if (path_q == P_DIRECT || path_q == P_DEGRADED) begin
                path_d = P_DISCOVERY;
              end else if (path_q == P_RECOVERY) begin
                path_d = saved_relay_side ? saved_q : P_REDISCOVERY;
              end
            end
            default: begin
              if (cur_relay_side) begin
                saved_d = path_q;
                path_d  = P_RECOVERY;
              end
            end
          endcase
        end
      end
      CMD_CANDIDATE: begin
        if (path_q == P_DISCOVERY || path_q == P_REDISCOVERY) begin
          path_d  = P_RELAY_AUTH;
          rfail_d = '0;
        end else begin
          status = ST_REJECT;
        end
      end
      CMD_RELAY_AUTH: begin
        if (path_q == P_RELAY_AUTH) begin
          path_d  = ok_i ? P_RELAY_ACTIVE : P_REDISCOVERY;
          rfail_d = '0;
        end else begin
          status = ST_REJECT;
        end
      end
      CMD_RELAY_RESULT: begin
        if (path_q != P_RELAY_ACTIVE) begin
          status = ST_REJECT;
        end else if (ok_i) begin
          rfail_d = '0;
        end else if (CmpW'(rfail_inc) >= CmpW'(relay_thr_i)) begin
          path_d  = P_REDISCOVERY;
          rfail_d = '0;
        end else begin
          rfail_d = rfail_inc;
        end
      end
      CMD_PEER_LOST: begin
        if (path_q == P_RELAY_ACTIVE || path_q == P_RELAY_AUTH) begin
          path_d  = P_REDISCOVERY;
          rfail_d = '0;
        end else if (path_q == P_RECOVERY) begin
          saved_d = P_REDISCOVERY;
        end else begin
          status = ST_REJECT;
        end
      end
      CMD_REDISCOVER: begin
        if (path_q == P_REDISCOVERY) begin
          path_d = P_DISCOVERY;
        end else begin
          status = ST_REJECT;
        end
      end
      default: status = ST_REJECT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      path_q  <= P_DIRECT;
      saved_q <= P_DIRECT;
      rfail_q <= '0;
    end else if (en_i) begin
      path_q  <= path_d;
      saved_q <= saved_d;
      rfail_q <= rfail_d;
    end
  end

  assign status_o = status;
  assign path_o   = path_d;
  assign rfail_o  = rfail_d;

endmodule

FILE: rtl/core/link_failover_path_controller.sv
// ----------------------------------------------------------------------------
// link_failover_path_controller
// Direct-link health tracking and relay failover path control.
// ----------------------------------------------------------------------------
// One request (command plus outcome flag) yields exactly one result: status,
// link health, path mode and relay failure count. A request lands in an input
// register, is evaluated combinationally against the health and path
// machines, and its result is held in an output register, so the block takes
// one request per clock unless the result side stalls. A stalled result
// holds the output register; one more request waits in the input register
// before in_stall_o rises. Configuration writes take effect at the next clock
// edge. The user makes them while the block is idle; the block does not check.
module link_failover_path_controller #(
  parameter int unsigned COUNTER_BITS = lfpc_pkg::CounterBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [lfpc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [lfpc_pkg::CfgW-1:0]    cfg_wdata_i,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [2:0]                   command_i,
  input  logic                         outcome_ok_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [1:0]                   link_health_o,
  output logic [2:0]                   path_mode_o,
  output logic [7:0]                   relay_fail_count_o
);
  import lfpc_pkg::*;

  localparam int unsigned ExtW = (COUNTER_BITS > 8) ? COUNTER_BITS : 8;

  cfg_t                    cfg;
  health_res_t             hres;
  status_e                 status;
  path_e                   path_mode;
  logic [COUNTER_BITS-1:0] rfail;
  logic [ExtW-1:0]         rfail_ext;

  logic       in_valid_d, in_valid_q;
  logic [2:0] cmd_q;
  logic       ok_q;
  logic       in_accept;
  logic       advance;

  logic       out_valid_d, out_valid_q;
  logic [1:0] status_q, health_q;
  logic [2:0] path_q;
  logic [7:0] rfail_q;

  // Handshake: move the held request forward when the result slot frees up
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept)    in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance)           out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q <= command_i;
      ok_q  <= outcome_ok_i;
    end
  end

  lfpc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lfpc_health #(
    .CounterBits (COUNTER_BITS)
  ) u_health (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .cmd_i  (cmd_e'(cmd_q)),
    .ok_i   (ok_q),
    .cfg_i  (cfg),
    .res_o  (hres)
  );

  lfpc_path #(
    .CounterBits (COUNTER_BITS)
  ) u_path (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .cmd_i       (cmd_e'(cmd_q)),
    .ok_i        (ok_q),
    .hres_i      (hres),
    .relay_thr_i (cfg.relay_fails_to_rediscover),
    .status_o    (status),
    .path_o      (path_mode),
    .rfail_o     (rfail)
  );

  // Report the low byte of the relay failure counter
  assign rfail_ext = ExtW'(rfail);

  // Hold the result until taken
  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q <= status;
      health_q <= hres.health;
      path_q   <= path_mode;
      rfail_q  <= rfail_ext[7:0];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign link_health_o      = health_q;
  assign path_mode_o        = path_q;
  assign relay_fail_count_o = rfail_q;

endmodule

FILE: tb/tb_link_failover_path_controller.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_link_failover_path_controller
// Self-checking bench for the link failover path controller: directed event
// walks through the health and path machines, policy checks and threshold
// extremes, then randomized event sequences under several threshold settings,
// with random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_link_failover_path_controller;
  import lfpc_pkg::*;

  // One expected result of the controller
  typedef struct packed {
    status_e    status;
    health_e    health;
    path_e      path;
    logic [7:0] relay_fails;
  } verdict_t;

  localparam logic [7:0]  CountMax      = 8'hFF;
  localparam logic [2:0]  CmdUnused     = 3'd7;
  localparam int unsigned IdlePct       = 18;
  localparam int unsigned WatchdogLimit = 2000;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                cfg_we     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx    = '0;
  logic [CfgW-1:0]     cfg_wdata  = '0;
  logic                in_valid   = 1'b0;
  logic                in_stall_o;
  logic [2:0]          command    = '0;
  logic                outcome_ok = 1'b0;
  logic                out_valid_o;
  logic                out_stall  = 1'b0;
  logic [1:0]          status_o;
  logic [1:0]          link_health_o;
  logic [2:0]          path_mode_o;
  logic [7:0]          relay_fail_count_o;

  // Bench control
  logic                quiet        = 1'b0;
  int unsigned         mismatches   = 0;
  int unsigned         idle_cycles  = 0;
  verdict_t            pending_verdicts[$];
  verdict_t            oldest;

  // Predicted controller state
  health_e             health_q       = H_HEALTHY;
  logic [7:0]          direct_fails_q = '0;
  logic [7:0]          probe_oks_q    = '0;
  path_e               path_q         = P_DIRECT;
  path_e               saved_path_q   = P_DIRECT;
  logic [7:0]          relay_fails_q  = '0;

  // Predicted thresholds
  logic [7:0]          thr_degraded    = FailsToDegradedRst;
  logic [7:0]          thr_unavailable = FailsToUnavailableRst;
  logic [7:0]          thr_probes      = ProbesToHealthyRst;
  logic [7:0]          thr_relay       = RelayFailsToRediscoverRst;

  link_failover_path_controller #(
    .COUNTER_BITS(CounterBitsDef)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall_o),
    .command_i         (command),
    .outcome_ok_i      (outcome_ok),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall),
    .status_o          (status_o),
    .link_health_o     (link_health_o),
    .path_mode_o       (path_mode_o),
    .relay_fail_count_o(relay_fail_count_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v >= CountMax) ? CountMax : v + 8'd1;
  endfunction

  function automatic logic health_policy_ok();
    return (thr_degraded != 0) && (thr_unavailable >= thr_degraded) && (thr_probes != 0);
  endfunction

  function automatic logic on_relay_side(input path_e m);
    return (m == P_DISCOVERY) || (m == P_RELAY_AUTH) || (m == P_RELAY_ACTIVE) ||
           (m == P_REDISCOVERY);
  endfunction

  // Move the path machine after a health update
  function automatic status_e follow_health();
    if (thr_relay == 0) return ST_POLICY;
    case (health_q)
      H_HEALTHY: begin
        path_q        = P_DIRECT;
        relay_fails_q = '0;
      end
      H_DEGRADED: begin
        if (path_q == P_DIRECT) path_q = P_DEGRADED;
      end
      H_UNAVAILABLE: begin
        if (path_q == P_DIRECT || path_q == P_DEGRADED) path_q = P_DISCOVERY;
        else if (path_q == P_RECOVERY)
          path_q = on_relay_side(saved_path_q) ? saved_path_q : P_REDISCOVERY;
      end
      default: begin
        if (on_relay_side(path_q)) begin
          saved_path_q = path_q;
          path_q       = P_RECOVERY;
        end
      end
    endcase
    return ST_NONE;
  endfunction

  // Apply one event and return the result it should produce
  function automatic verdict_t advance_controller(input logic [2:0] cmd, input logic ok);
    status_e  st;
    verdict_t res;
    case (cmd)
      CMD_DIRECT_RESULT: begin
        if (!health_policy_ok()) st = ST_POLICY;
        else if (health_q == H_UNAVAILABLE || health_q == H_RECOVERING) st = ST_REJECT;
        else begin
          probe_oks_q = '0;
          if (ok) begin
            direct_fails_q = '0;
            health_q       = H_HEALTHY;
          end else begin
            direct_fails_q = sat_inc(direct_fails_q);
            if (direct_fails_q >= thr_unavailable) health_q = H_UNAVAILABLE;
            else if (direct_fails_q >= thr_degraded) health_q = H_DEGRADED;
          end
          st = follow_health();
        end
      end
      CMD_PROBE: begin
        if (!health_policy_ok()) st = ST_POLICY;
        else if (health_q != H_UNAVAILABLE && health_q != H_RECOVERING) st = ST_REJECT;
        else begin
          if (!ok) begin
            probe_oks_q = '0;
            health_q    = H_UNAVAILABLE;
          end else begin
            probe_oks_q = sat_inc(probe_oks_q);
            if (probe_oks_q >= thr_probes) begin
              direct_fails_q = '0;
              probe_oks_q    = '0;
              health_q       = H_HEALTHY;
            end else begin
              health_q = H_RECOVERING;
            end
          end
          st = follow_health();
        end
      end
      CMD_CANDIDATE: begin
        if (path_q == P_DISCOVERY || path_q == P_REDISCOVERY) begin
          path_q        = P_RELAY_AUTH;
          relay_fails_q = '0;
          st            = ST_NONE;
        end else begin
          st = ST_REJECT;
        end
      end
      CMD_RELAY_AUTH: begin
        if (path_q == P_RELAY_AUTH) begin
          path_q        = ok ? P_RELAY_ACTIVE : P_REDISCOVERY;
          relay_fails_q = '0;
          st            = ST_NONE;
        end else begin
          st = ST_REJECT;
        end
      end
      CMD_RELAY_RESULT: begin
        if (path_q != P_RELAY_ACTIVE) st = ST_REJECT;
        else begin
          st = ST_NONE;
          if (ok) relay_fails_q = '0;
          else begin
            relay_fails_q = sat_inc(relay_fails_q);
            if (relay_fails_q >= thr_relay) begin
              path_q        = P_REDISCOVERY;
              relay_fails_q = '0;
            end
          end
        end
      end
      CMD_PEER_LOST: begin
        if (path_q == P_RELAY_ACTIVE || path_q == P_RELAY_AUTH) begin
          path_q        = P_REDISCOVERY;
          relay_fails_q = '0;
          st            = ST_NONE;
        end else if (path_q == P_RECOVERY) begin
          saved_path_q = P_REDISCOVERY;
          st           = ST_NONE;
        end else begin
          st = ST_REJECT;
        end
      end
      CMD_REDISCOVER: begin
        if (path_q == P_REDISCOVERY) begin
          path_q = P_DISCOVERY;
          st     = ST_NONE;
        end else begin
          st = ST_REJECT;
        end
      end
      default: st = ST_REJECT;
    endcase
    res.status      = st;
    res.health      = health_q;
    res.path        = path_q;
    res.relay_fails = relay_fails_q;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stalls, checking, watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (!rst_ni || quiet) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < IdlePct);
  end

  task automatic flag_mismatch(input string field, input logic [7:0] want, input logic [7:0] got);
    $display("%0t: %s differs: expected %0d, actual %0d", $time, field, want, got);
    mismatches++;
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: result with no request pending: status %0d health %0d path %0d count %0d",
                 $time, status_o, link_health_o, path_mode_o, relay_fail_count_o);
        mismatches++;
      end else begin
        oldest = pending_verdicts.pop_front();
        if (status_o !== oldest.status)
          flag_mismatch("status", 8'(oldest.status), 8'(status_o));
        if (link_health_o !== oldest.health)
          flag_mismatch("link_health", 8'(oldest.health), 8'(link_health_o));
        if (path_mode_o !== oldest.path)
          flag_mismatch("path_mode", 8'(oldest.path), 8'(path_mode_o));
        if (relay_fail_count_o !== oldest.relay_fails)
          flag_mismatch("relay_fail_count", oldest.relay_fails, relay_fail_count_o);
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Send one request, hold it until accepted, then record its expected result
  task automatic issue_event(input logic [2:0] cmd, input logic ok);
    verdict_t expected;
    if (!quiet && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    outcome_ok <= ok;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected         = advance_controller(cmd, ok);
    pending_verdicts = {pending_verdicts, expected};
  endtask

  // Drop valid and wait until every result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write all four thresholds once the block is idle
  task automatic load_thresholds(input logic [7:0] ftd, input logic [7:0] ftu,
                                 input logic [7:0] pth, input logic [7:0] rfr);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_FAILS_TO_DEGRADED;
    cfg_wdata <= ftd;
    @(posedge clk_i);
    cfg_idx   <= CFG_FAILS_TO_UNAVAILABLE;
    cfg_wdata <= ftu;
    @(posedge clk_i);
    cfg_idx   <= CFG_PROBES_TO_HEALTHY;
    cfg_wdata <= pth;
    @(posedge clk_i);
    cfg_idx   <= CFG_RELAY_FAILS_TO_REDISCOVER;
    cfg_wdata <= rfr;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
    thr_degraded    = ftd;
    thr_unavailable = ftu;
    thr_probes      = pth;
    thr_relay       = rfr;
  endtask

  // Random events, mostly ones the current state allows. A harsh setting
  // (bad_pct of 95 or more) drops noise and peer loss to drive counters high.
  task automatic run_phase(input int unsigned bad_pct, input int unsigned count);
    logic [2:0]  legal[$];
    logic [2:0]  cmd;
    logic        ok;
    int unsigned roll;
    logic        harsh;
    harsh = (bad_pct >= 95);
    for (int n = 0; n < count; n++) begin
      legal.delete();
      if (health_q == H_HEALTHY || health_q == H_DEGRADED) legal = {legal, CMD_DIRECT_RESULT};
      else legal = {legal, CMD_PROBE};
      case (path_q)
        P_DISCOVERY: legal = {legal, CMD_CANDIDATE};
        P_REDISCOVERY: begin
          legal = {legal, CMD_CANDIDATE};
          legal = {legal, CMD_REDISCOVER};
        end
        P_RELAY_AUTH: begin
          legal = {legal, CMD_RELAY_AUTH};
          if (!harsh) legal = {legal, CMD_PEER_LOST};
        end
        P_RELAY_ACTIVE: begin
          legal = {legal, CMD_RELAY_RESULT};
          if (!harsh) legal = {legal, CMD_PEER_LOST};
        end
        P_RECOVERY: begin
          if (!harsh) legal = {legal, CMD_PEER_LOST};
        end
        default: ;
      endcase
      if (!harsh && $urandom_range(99) < 15) begin
        cmd = 3'($urandom_range(7, 0));
        ok  = 1'($urandom_range(1, 0));
      end else begin
        cmd  = legal[$urandom_range(legal.size() - 1, 0)];
        roll = $urandom_range(99);
        case (cmd) inside
          CMD_DIRECT_RESULT, CMD_RELAY_RESULT: ok = (roll >= bad_pct);
          CMD_PROBE: ok = (roll >= bad_pct / 2);
          default: ok = (roll < 80);
        endcase
      end
      issue_event(cmd, ok);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Unused command and events the reset state does not allow
  task automatic test_rejects_at_reset();
    issue_event(CmdUnused, 1'b0);
    issue_event(CmdUnused, 1'b1);
    issue_event(CMD_CANDIDATE, 1'b1);
    issue_event(CMD_REDISCOVER, 1'b0);
    issue_event(CMD_PROBE, 1'b1);
  endtask

  // Walk the link down to relay operation and back with reset thresholds
  task automatic test_failover_walk();
    issue_event(CMD_DIRECT_RESULT, 1'b1);
    repeat (3) issue_event(CMD_DIRECT_RESULT, 1'b0);
    repeat (2) issue_event(CMD_DIRECT_RESULT, 1'b0);
    issue_event(CMD_DIRECT_RESULT, 1'b0);
    issue_event(CMD_PROBE, 1'b1);
    issue_event(CMD_PEER_LOST, 1'b1);
    issue_event(CMD_PROBE, 1'b0);
    issue_event(CMD_REDISCOVER, 1'b1);
    issue_event(CMD_CANDIDATE, 1'b0);
    issue_event(CMD_RELAY_AUTH, 1'b0);
    issue_event(CMD_CANDIDATE, 1'b1);
    issue_event(CMD_RELAY_AUTH, 1'b1);
    issue_event(CMD_RELAY_RESULT, 1'b0);
    issue_event(CMD_RELAY_RESULT, 1'b1);
    repeat (3) issue_event(CMD_RELAY_RESULT, 1'b0);
    issue_event(CMD_CANDIDATE, 1'b0);
    issue_event(CMD_RELAY_AUTH, 1'b1);
    issue_event(CMD_PEER_LOST, 1'b0);
    repeat (2) issue_event(CMD_PROBE, 1'b1);
  endtask

  // Invalid health and path policies
  task automatic test_policy_checks();
    load_thresholds(8'd0, 8'd5, 8'd2, 8'd3);
    issue_event(CMD_DIRECT_RESULT, 1'b0);
    issue_event(CMD_PROBE, 1'b1);
    load_thresholds(8'd4, 8'd3, 8'd2, 8'd3);
    issue_event(CMD_DIRECT_RESULT, 1'b0);
    load_thresholds(8'd3, 8'd5, 8'd0, 8'd3);
    issue_event(CMD_DIRECT_RESULT, 1'b1);
    issue_event(CMD_PROBE, 1'b1);
    // health still moves while the path machine is frozen
    load_thresholds(8'd1, 8'd2, 8'd1, 8'd0);
    issue_event(CMD_DIRECT_RESULT, 1'b0);
    issue_event(CMD_DIRECT_RESULT, 1'b0);
    issue_event(CMD_PROBE, 1'b1);
  endtask

  // Every threshold at one
  task automatic test_smallest_thresholds();
    load_thresholds(8'd1, 8'd1, 8'd1, 8'd1);
    run_phase(60, 150);
  endtask

  // Every threshold at its maximum, events pushed toward the counter limits
  task automatic test_counter_limits();
    load_thresholds(8'd255, 8'd255, 8'd255, 8'd255);
    run_phase(100, 900);
  endtask

  // Random thresholds, invalid policies included; the first phase never idles
  task automatic test_random_configs();
    for (int ph = 0; ph < 9; ph++) begin
      load_thresholds(8'($urandom_range(6, 0)), 8'($urandom_range(8, 0)),
                      8'($urandom_range(4, 0)), 8'($urandom_range(5, 0)));
      quiet <= (ph == 0);
      run_phase($urandom_range(70, 50), 100);
    end
    quiet <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_rejects_at_reset();
    test_failover_walk();
    test_policy_checks();
    test_smallest_thresholds();
    test_counter_limits();
    test_random_configs();
    drain_results();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
